### design/gru_pkg.sv
// shared types, constants and helpers for the grid range update unit
// no dependencies
package gru_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int ROW_W    = $clog2(MAX_ROWS);
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int DIM_W    = 7;
   localparam int DSTRIDE  = MAX_COLS + 1;
   localparam int DCELLS   = (MAX_ROWS + 1) * (MAX_COLS + 1);
   localparam int DADDR_W  = $clog2(DCELLS);
   localparam int GCELLS   = MAX_ROWS * MAX_COLS;
   localparam int GADDR_W  = $clog2(GCELLS);
   localparam int SUM_W    = 40;
   localparam int VAL_W    = 16;
   localparam int CNT_W    = 13;
   localparam int CIDX_W   = 2;
   localparam int CDATA_W  = 16;

   // item modes
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_UPDATE = 2'd1;
   localparam logic [1:0] MODE_FINISH = 2'd2;

   // register indexes
   localparam logic [CIDX_W-1:0] REG_ROWS   = 2'd0;
   localparam logic [CIDX_W-1:0] REG_COLS   = 2'd1;
   localparam logic [CIDX_W-1:0] REG_THRESH = 2'd2;

   typedef struct packed {
      logic [1:0]       mode;
      logic [ROW_W-1:0] row_top;
      logic [COL_W-1:0] col_left;
      logic [ROW_W-1:0] row_bottom;
      logic [COL_W-1:0] col_right;
      logic             is_attack;
      logic [VAL_W-1:0] amount;
      logic [VAL_W-1:0] cell_value;
   } item_type;

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic upd_run;
      logic sweep_rd;
      logic sweep_row;
      logic sweep_col;
      logic sweep_cmp;
      logic clr_run;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       rect_ok;
      logic       cnr_last;
      logic       cell_last;
      logic       grid_empty;
      logic       clr_last;
      logic       rsp_busy;
   } status_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             ovf;
   } add_type;

   // 40-bit two's complement add with wrap detect
   function automatic add_type add40(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b);
      add_type r;
      r.sum = a + b;
      r.ovf = (a[SUM_W-1] == b[SUM_W-1]) && (r.sum[SUM_W-1] != a[SUM_W-1]);
      return r;
   endfunction

   function automatic logic [DADDR_W-1:0] dif_addr(input logic [DIM_W-1:0] r,
                                                   input logic [DIM_W-1:0] c);
      return DADDR_W'(r) * DADDR_W'(DSTRIDE) + DADDR_W'(c);
   endfunction

endpackage

### design/gru_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module gru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

### design/gru_ctrl.sv
// sequencer for load, rectangle update, finish sweep and clearing pass
// depends on gru_pkg
module gru_ctrl
   import gru_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DEC   = 4'd2;
   localparam logic [3:0] S_UPD   = 4'd3;
   localparam logic [3:0] S_FRD   = 4'd4;
   localparam logic [3:0] S_FROW  = 4'd5;
   localparam logic [3:0] S_FCOL  = 4'd6;
   localparam logic [3:0] S_FCMP  = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_run = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            priority if (status.mode == MODE_LOAD) begin
               cmd.load_wr = 1'b1;
               state_in    = S_IDLE;
            end else if (status.mode == MODE_UPDATE) begin
               state_in = status.rect_ok ? S_UPD : S_IDLE;
            end else if (status.mode == MODE_FINISH) begin
               state_in = status.grid_empty ? S_EMIT : S_FRD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_UPD: begin
            cmd.upd_run = 1'b1;
            if (status.cnr_last) state_in = S_IDLE;
         end
         S_FRD: begin
            cmd.sweep_rd = 1'b1;
            state_in     = S_FROW;
         end
         S_FROW: begin
            cmd.sweep_row = 1'b1;
            state_in      = S_FCOL;
         end
         S_FCOL: begin
            cmd.sweep_col = 1'b1;
            state_in      = S_FCMP;
         end
         S_FCMP: begin
            cmd.sweep_cmp = 1'b1;
            state_in      = status.cell_last ? S_EMIT : S_FRD;
         end
         S_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_CLEAR;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

endmodule

### design/gru_datapath.sv
// item capture, config registers, rams, prefix sum and count datapath
// depends on gru_pkg and gru_ram
module gru_datapath
   import gru_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  item_type           req_item,
   input  logic               csr_we,
   input  logic [CIDX_W-1:0]  csr_index,
   input  logic [CDATA_W-1:0] csr_wdata,
   input  cmd_type            cmd,
   output status_type         status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CNT_W-1:0]   rsp_count,
   output logic               rsp_ovf
);

   item_type           item_ff;
   logic [DIM_W-1:0]   rows_ff, cols_ff;
   logic [VAL_W-1:0]   thresh_ff;
   logic [2:0]         cnr_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [COL_W-1:0]   col_ff;
   logic [DADDR_W-1:0] clr_ff;
   logic [SUM_W-1:0]   racc_ff, cacc_ff, colv_ff;
   logic [VAL_W-1:0]   grid_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               ovf_ff;
   logic               rsp_valid_ff;
   logic [CNT_W-1:0]   rsp_count_ff;
   logic               rsp_ovf_ff;

   logic [DIM_W-1:0]   nr, nc;
   logic [SUM_W-1:0]   delta;
   logic [DADDR_W-1:0] cnr_addr [4];
   logic [SUM_W-1:0]   cnr_delta [4];
   logic [1:0]         wr_cnr;
   add_type            upd_sum, row_sum, col_sum;
   logic               dif_we;
   logic [DADDR_W-1:0] dif_waddr, dif_raddr;
   logic [SUM_W-1:0]   dif_wdata, dif_rdata, colbuf_rdata;
   logic [VAL_W-1:0]   grid_rdata;
   logic signed [SUM_W+1:0] final_val;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= DIM_W'(MAX_ROWS);
         cols_ff   <= DIM_W'(MAX_COLS);
         thresh_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ROWS:   rows_ff   <= csr_wdata[DIM_W-1:0];
            REG_COLS:   cols_ff   <= csr_wdata[DIM_W-1:0];
            REG_THRESH: thresh_ff <= csr_wdata;
            default:    ;
         endcase
      end
   end

   assign nr = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign nc = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_item;
   end

   // corner addresses and signed deltas
   assign delta = item_ff.is_attack ? -SUM_W'(item_ff.amount) : SUM_W'(item_ff.amount);
   always_comb begin
      cnr_addr[0]  = dif_addr(DIM_W'(item_ff.row_top), DIM_W'(item_ff.col_left));
      cnr_addr[1]  = dif_addr(DIM_W'(item_ff.row_bottom) + 1'b1, DIM_W'(item_ff.col_left));
      cnr_addr[2]  = dif_addr(DIM_W'(item_ff.row_top), DIM_W'(item_ff.col_right) + 1'b1);
      cnr_addr[3]  = dif_addr(DIM_W'(item_ff.row_bottom) + 1'b1,
                              DIM_W'(item_ff.col_right) + 1'b1);
      cnr_delta[0] = delta;
      cnr_delta[1] = -delta;
      cnr_delta[2] = -delta;
      cnr_delta[3] = delta;
   end

   assign wr_cnr  = 2'(cnr_ff - 3'd1);
   assign upd_sum = add40(dif_rdata, cnr_delta[wr_cnr]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnr_ff <= '0;
      end else if (cmd.upd_run) begin
         cnr_ff <= (cnr_ff == 3'd4) ? 3'd0 : cnr_ff + 3'd1;
      end
   end

   // sweep counters
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (cmd.sweep_cmp) begin
         if (DIM_W'(col_ff) == nc - 1'b1) begin
            col_ff <= '0;
            row_ff <= (DIM_W'(row_ff) == nr - 1'b1) ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_run) begin
         clr_ff <= (clr_ff == DADDR_W'(DCELLS - 1)) ? '0 : clr_ff + 1'b1;
      end
   end

   // difference memory ports
   always_comb begin
      dif_raddr = cmd.upd_run ? cnr_addr[cnr_ff[1:0]]
                              : dif_addr(DIM_W'(row_ff), DIM_W'(col_ff));
      dif_we    = 1'b0;
      dif_waddr = clr_ff;
      dif_wdata = '0;
      if (cmd.clr_run) begin
         dif_we = 1'b1;
      end else if (cmd.upd_run && cnr_ff != 3'd0) begin
         dif_we    = 1'b1;
         dif_waddr = cnr_addr[wr_cnr];
         dif_wdata = upd_sum.sum;
      end
   end

   gru_ram #(.WIDTH(SUM_W), .DEPTH(DCELLS)) u_dif_ram (
      .clock   (clock),
      .wr_en   (dif_we),
      .wr_addr (dif_waddr),
      .wr_data (dif_wdata),
      .rd_addr (dif_raddr),
      .rd_data (dif_rdata)
   );

   gru_ram #(.WIDTH(VAL_W), .DEPTH(GCELLS)) u_grid_ram (
      .clock   (clock),
      .wr_en   (cmd.load_wr),
      .wr_addr ({item_ff.row_top, item_ff.col_left}),
      .wr_data (item_ff.cell_value),
      .rd_addr ({row_ff, col_ff}),
      .rd_data (grid_rdata)
   );

   gru_ram #(.WIDTH(SUM_W), .DEPTH(MAX_COLS)) u_col_ram (
      .clock   (clock),
      .wr_en   (cmd.sweep_col),
      .wr_addr (col_ff),
      .wr_data (col_sum.sum),
      .rd_addr (col_ff),
      .rd_data (colbuf_rdata)
   );

   // row then column prefix, one add per cycle
   assign row_sum = add40((col_ff == '0) ? '0 : racc_ff, dif_rdata);
   assign col_sum = add40((row_ff == '0) ? '0 : colv_ff, racc_ff);

   always_ff @(posedge clock) begin
      if (cmd.sweep_row) begin
         racc_ff <= row_sum.sum;
         grid_ff <= grid_rdata;
         colv_ff <= colbuf_rdata;
      end
      if (cmd.sweep_col) cacc_ff <= col_sum.sum;
   end

   assign final_val = $signed({{(SUM_W+2-VAL_W){1'b0}}, grid_ff})
                    + $signed({{2{cacc_ff[SUM_W-1]}}, cacc_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         if (cmd.emit) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end else begin
            if (cmd.sweep_cmp &&
                final_val > $signed({{(SUM_W+2-VAL_W){1'b0}}, thresh_ff})) begin
               count_ff <= count_ff + 1'b1;
            end
            if ((cmd.upd_run && cnr_ff != 3'd0 && upd_sum.ovf) ||
                (cmd.sweep_row && row_sum.ovf) || (cmd.sweep_col && col_sum.ovf)) begin
               ovf_ff <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_count_ff <= count_ff;
         rsp_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_ovf   = rsp_ovf_ff;

   assign status.mode       = item_ff.mode;
   assign status.rect_ok    = (item_ff.row_top <= item_ff.row_bottom) &&
                              (item_ff.col_left <= item_ff.col_right);
   assign status.cnr_last   = (cnr_ff == 3'd4);
   assign status.cell_last  = (DIM_W'(row_ff) == nr - 1'b1) && (DIM_W'(col_ff) == nc - 1'b1);
   assign status.grid_empty = (nr == '0) || (nc == '0);
   assign status.clr_last   = (clr_ff == DADDR_W'(DCELLS - 1));
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

`ifndef ASSERT_OFF
   a_cnr_range: assert property (@(posedge clock) disable iff (reset) cnr_ff <= 3'd4)
      else $error("corner counter out of range");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(GCELLS))
      else $error("survivor count above grid size");
   a_sweep_rows: assert property (@(posedge clock) disable iff (reset)
      cmd.sweep_rd |-> (DIM_W'(row_ff) < nr && DIM_W'(col_ff) < nc))
      else $error("sweep outside rows or columns in use");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before taken");
`endif

endmodule

### design/grid_range_update_threshold_count_unit.sv
// grid range update with threshold count: load writes one grid cell, a rectangle update
// rewrites four difference corners (none if ignored); finish steps each cell in use
// through read, row add, column add and compare (row/column prefix add chain through the
// difference ram), emits the result once the previous one is taken, then runs a clearing
// pass of the difference ram, as after reset; reset is synchronous active high, sets
// rows/cols to 64, threshold to 0; depends on gru_pkg, gru_ctrl, gru_datapath, gru_ram
module grid_range_update_threshold_count_unit
   import gru_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request beats
   input  logic               req_tvalid,
   output logic               req_tready,
   // row_top, col_left, row_bottom, col_right, is_attack, amount, cell_value, zero fill
   input  logic [63:0]        req_tdata,
   // mode
   input  logic [1:0]         req_tuser,
   // response beats
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // survivor_count, overflow_flag, zero fill
   output logic [15:0]        rsp_tdata,
   // config writes
   input  logic               csr_we,
   input  logic [CIDX_W-1:0]  csr_index,
   input  logic [CDATA_W-1:0] csr_wdata
);

   item_type         item;
   cmd_type          cmd;
   status_type       status;
   logic [CNT_W-1:0] count;
   logic             ovf;

   // unpack the request beat
   assign item.mode       = req_tuser;
   assign item.row_top    = req_tdata[5:0];
   assign item.col_left   = req_tdata[11:6];
   assign item.row_bottom = req_tdata[17:12];
   assign item.col_right  = req_tdata[23:18];
   assign item.is_attack  = req_tdata[24];
   assign item.amount     = req_tdata[40:25];
   assign item.cell_value = req_tdata[56:41];

   gru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gru_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_count (count),
      .rsp_ovf   (ovf)
   );

   assign rsp_tdata = {2'b00, ovf, count};

endmodule
